FILE: rtl/periodic_sensor_acquisition_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Periodic sensor acquisition sequencer: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SENSOR_ACQUISITION_SEQUENCER_DEFINES_SVH
`define PERIODIC_SENSOR_ACQUISITION_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PSAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PSAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/psas_pkg.sv
// ----------------------------------------------------------------------------
// psas_pkg
// Types and codes shared by the acquisition sequencer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package psas_pkg;

  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 40;
  localparam int CFG_W    = 32;
  localparam int CNT_W    = 32;
  localparam int CMP_W    = 64;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCFG  = 3'd1,
    ST_NOINIT  = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_DRVERR  = 3'd4
  } status_t;

  localparam logic       FUNC_BEGIN = 1'b0;
  localparam logic       FUNC_POLL  = 1'b1;

  localparam logic [1:0] DRV_OK     = 2'd0;
  localparam logic [1:0] DRV_BUSY   = 2'd1;

  localparam logic       REG_SAMPLE_INTERVAL = 1'b0;
  localparam logic       REG_MEAS_TIMEOUT    = 1'b1;

  localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] MEAS_TIMEOUT_RST    = CFG_W'(100);

  typedef struct packed {
    logic                func;
    logic [TIME_W-1:0]   now_ms;
    logic [1:0]          driver_status;
    logic [SAMPLE_W-1:0] sample_word;
  } psas_in_t;

  typedef struct packed {
    status_t             status;
    logic                trigger_issued;
    logic                sample_stored;
    logic                measuring_now;
    logic [SAMPLE_W-1:0] latest_sample;
    logic [CNT_W-1:0]    latest_sample_id;
    logic [TIME_W-1:0]   latest_sample_time;
    logic [CNT_W-1:0]    failure_count;
  } psas_out_t;

endpackage

`default_nettype wire

FILE: rtl/periodic_sensor_acquisition_sequencer.sv
// ----------------------------------------------------------------------------
// Periodic sensor acquisition sequencer
// Begin/poll sequencing of periodic measurements with timeout and counters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data   (psas_in_t)
//  out     | output    | out_valid / out_ready | out_data  (psas_out_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One request per cycle; its result is in the output register in the cycle
//  after acceptance. The state update and result are one combinational pass
//  from the request and the state registers into the output register.
//  in_ready is low only while a result is held and out_ready is low.
//  Synchronous reset restores configuration defaults and clears state.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_sensor_acquisition_sequencer
  import psas_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire psas_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output psas_out_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0]    sample_interval;
  logic [CFG_W-1:0]    meas_timeout;

  logic                armed, armed_next;
  logic                busy_measuring, busy_measuring_next;
  logic                first_pending, first_pending_next;
  logic [TIME_W-1:0]   cycle_start, cycle_start_next;
  logic [SAMPLE_W-1:0] held_sample, held_sample_next;
  logic [TIME_W-1:0]   held_sample_time, held_sample_time_next;
  logic [CNT_W-1:0]    sample_counter, sample_counter_next;
  logic [CNT_W-1:0]    fail_counter, fail_counter_next;

  logic                in_fire;
  logic [TIME_W-1:0]   since_start;
  logic                interval_due, timeout_due;
  logic [CNT_W-1:0]    sample_inc;
  status_t             status_next;
  logic                trig_next, stored_next;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign since_start  = in_data.now_ms - cycle_start;
  assign interval_due = CMP_W'(since_start) >= CMP_W'(sample_interval);
  assign timeout_due  = CMP_W'(since_start) >= CMP_W'(meas_timeout);
  // id zero is reserved for "no sample yet"
  assign sample_inc   = (sample_counter == '1) ? CNT_W'(1) : sample_counter + CNT_W'(1);

  always_comb begin
    armed_next            = armed;
    busy_measuring_next   = busy_measuring;
    first_pending_next    = first_pending;
    cycle_start_next      = cycle_start;
    held_sample_next      = held_sample;
    held_sample_time_next = held_sample_time;
    sample_counter_next   = sample_counter;
    fail_counter_next     = fail_counter;
    status_next           = ST_OK;
    trig_next             = 1'b0;
    stored_next           = 1'b0;

    if (in_data.func == FUNC_BEGIN) begin
      armed_next = 1'b0;
      if (sample_interval == '0 || meas_timeout == '0) begin
        status_next = ST_BADCFG;
      end else if (in_data.driver_status != DRV_OK) begin
        status_next = ST_DRVERR;
      end else begin
        busy_measuring_next = 1'b0;
        first_pending_next  = 1'b1;
        armed_next          = 1'b1;
      end
    end else if (!armed) begin
      status_next = ST_NOINIT;
    end else if (!busy_measuring) begin
      if (first_pending || interval_due) begin
        first_pending_next = 1'b0;
        cycle_start_next   = in_data.now_ms;
        trig_next          = 1'b1;
        if (in_data.driver_status != DRV_OK) begin
          fail_counter_next = fail_counter + CNT_W'(1);
          status_next       = ST_DRVERR;
        end else begin
          busy_measuring_next = 1'b1;
        end
      end
    end else if (in_data.driver_status == DRV_OK) begin
      busy_measuring_next   = 1'b0;
      held_sample_next      = in_data.sample_word;
      held_sample_time_next = in_data.now_ms;
      sample_counter_next   = sample_inc;
      stored_next           = 1'b1;
    end else if (in_data.driver_status == DRV_BUSY) begin
      if (timeout_due) begin
        busy_measuring_next = 1'b0;
        fail_counter_next   = fail_counter + CNT_W'(1);
        status_next         = ST_TIMEOUT;
      end
    end else begin
      busy_measuring_next = 1'b0;
      fail_counter_next   = fail_counter + CNT_W'(1);
      status_next         = ST_DRVERR;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= SAMPLE_INTERVAL_RST;
      meas_timeout    <= MEAS_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data;
        REG_MEAS_TIMEOUT:    meas_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed            <= 1'b0;
      busy_measuring   <= 1'b0;
      first_pending    <= 1'b1;
      cycle_start      <= '0;
      held_sample      <= '0;
      held_sample_time <= '0;
      sample_counter   <= '0;
      fail_counter     <= '0;
    end else if (in_fire) begin
      armed            <= armed_next;
      busy_measuring   <= busy_measuring_next;
      first_pending    <= first_pending_next;
      cycle_start      <= cycle_start_next;
      held_sample      <= held_sample_next;
      held_sample_time <= held_sample_time_next;
      sample_counter   <= sample_counter_next;
      fail_counter     <= fail_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.status             <= status_next;
      out_data.trigger_issued     <= trig_next;
      out_data.sample_stored      <= stored_next;
      out_data.measuring_now      <= busy_measuring_next;
      out_data.latest_sample      <= held_sample_next;
      out_data.latest_sample_id   <= sample_counter_next;
      out_data.latest_sample_time <= held_sample_time_next;
      out_data.failure_count      <= fail_counter_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psas_checker.sv
// ----------------------------------------------------------------------------
// psas_checker
// Port-level checks on the acquisition sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_sensor_acquisition_sequencer_defines.svh"

module psas_checker
  import psas_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire psas_out_t out_data
);

  // held result must not move while stalled
  `PSAS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // every accepted request yields a result next cycle
  `PSAS_ASSERT_NEXT(a_req_result, clk, rst, in_valid && in_ready, out_valid, "accepted request gave no result")

  // a stored sample always carries a nonzero id
  `PSAS_ASSERT_NOW(a_id_nonzero, clk, rst, out_valid && out_data.sample_stored, out_data.latest_sample_id != '0, "stored sample has id zero")

  // trigger and read never happen on the same request
  `PSAS_ASSERT_NOW(a_trig_read, clk, rst, out_valid && out_data.trigger_issued, !out_data.sample_stored, "trigger and store together")

  // timeout always ends the measurement
  `PSAS_ASSERT_NOW(a_timeout_end, clk, rst, out_valid && out_data.status == ST_TIMEOUT, !out_data.measuring_now, "still measuring after timeout")

endmodule

bind periodic_sensor_acquisition_sequencer psas_checker u_psas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/acquisition_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Acquisition checker
// Watches the request, result and register channels of the sequencer, keeps
// its own copy of the sequencing state, predicts each result and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module acquisition_checker
  import psas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  psas_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  psas_out_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int unsigned      fault_count,
  output int unsigned      outstanding
);

  logic [CFG_W-1:0]    interval_ms;
  logic [CFG_W-1:0]    timeout_ms;
  logic                is_armed;
  logic                measuring;
  logic                first_due;
  logic [TIME_W-1:0]   start_ms;
  logic [SAMPLE_W-1:0] held_word;
  logic [TIME_W-1:0]   held_time;
  logic [CNT_W-1:0]    sample_id;
  logic [CNT_W-1:0]    fail_total;
  psas_out_t           expected_results[$];
  int unsigned         result_no;

  initial begin
    fault_count = 0;
    outstanding = 0;
    result_no   = 0;
  end

  // wrapping difference, so a start just before the wrap still counts
  function automatic logic span_reached(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] start,
                                        input logic [CFG_W-1:0]  span);
    logic [TIME_W-1:0] diff;
    diff = now - start;
    return diff >= span;
  endfunction

  task automatic advance_sequencer(input psas_in_t req, output psas_out_t res);
    res        = '0;
    res.status = ST_OK;
    if (req.func == FUNC_BEGIN) begin
      is_armed = 1'b0;
      if (interval_ms == '0 || timeout_ms == '0) begin
        res.status = ST_BADCFG;
      end else if (req.driver_status != DRV_OK) begin
        res.status = ST_DRVERR;
      end else begin
        measuring = 1'b0;
        first_due = 1'b1;
        is_armed  = 1'b1;
      end
    end else if (!is_armed) begin
      res.status = ST_NOINIT;
    end else if (!measuring) begin
      if (first_due || span_reached(req.now_ms, start_ms, interval_ms)) begin
        first_due          = 1'b0;
        start_ms           = req.now_ms;
        res.trigger_issued = 1'b1;
        if (req.driver_status != DRV_OK) begin
          fail_total = fail_total + 1'b1;
          res.status = ST_DRVERR;
        end else begin
          measuring = 1'b1;
        end
      end
    end else if (req.driver_status == DRV_OK) begin
      measuring = 1'b0;
      held_word = req.sample_word;
      held_time = req.now_ms;
      sample_id = sample_id + 1'b1;
      // id zero means no sample, so the wrap skips it
      if (sample_id == '0) begin
        sample_id = 1;
      end
      res.sample_stored = 1'b1;
    end else if (req.driver_status == DRV_BUSY) begin
      if (span_reached(req.now_ms, start_ms, timeout_ms)) begin
        measuring  = 1'b0;
        fail_total = fail_total + 1'b1;
        res.status = ST_TIMEOUT;
      end
    end else begin
      measuring  = 1'b0;
      fail_total = fail_total + 1'b1;
      res.status = ST_DRVERR;
    end
    res.measuring_now      = measuring;
    res.latest_sample      = held_word;
    res.latest_sample_id   = sample_id;
    res.latest_sample_time = held_time;
    res.failure_count      = fail_total;
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("result %0d: %s expected %0h, got %0h", result_no, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    psas_out_t want;
    if (rst) begin
      interval_ms = SAMPLE_INTERVAL_RST;
      timeout_ms  = MEAS_TIMEOUT_RST;
      is_armed    = 1'b0;
      measuring   = 1'b0;
      first_due   = 1'b1;
      start_ms    = '0;
      held_word   = '0;
      held_time   = '0;
      sample_id   = '0;
      fail_total  = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result %0d arrived with no request waiting", result_no);
          end
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 64'(want.status), 64'(out_data.status));
          compare_field("trigger_issued", 64'(want.trigger_issued),
                        64'(out_data.trigger_issued));
          compare_field("sample_stored", 64'(want.sample_stored),
                        64'(out_data.sample_stored));
          compare_field("measuring_now", 64'(want.measuring_now),
                        64'(out_data.measuring_now));
          compare_field("latest_sample", 64'(want.latest_sample),
                        64'(out_data.latest_sample));
          compare_field("latest_sample_id", 64'(want.latest_sample_id),
                        64'(out_data.latest_sample_id));
          compare_field("latest_sample_time", 64'(want.latest_sample_time),
                        64'(out_data.latest_sample_time));
          compare_field("failure_count", 64'(want.failure_count),
                        64'(out_data.failure_count));
        end
        result_no++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SAMPLE_INTERVAL) begin
          interval_ms = cfg_data;
        end else begin
          timeout_ms = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        advance_sequencer(in_data, want);
        expected_results.push_back(want);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Acquisition sequencer testbench
// Drives begin and poll requests with a simulated millisecond clock, register
// writes between phases and random stalls on both channels; the checker
// predicts and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import psas_pkg::*;

  localparam logic [1:0] DRV_ERROR     = 2'd2;
  localparam logic [1:0] DRV_UNDEFINED = 2'd3;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 4;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  psas_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  psas_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = REG_SAMPLE_INTERVAL;
  logic [CFG_W-1:0] cfg_data  = '0;

  int unsigned       fault_count;
  int unsigned       outstanding;
  logic [TIME_W-1:0] clock_ms    = '0;
  logic [CFG_W-1:0]  cur_interval = SAMPLE_INTERVAL_RST;
  logic [CFG_W-1:0]  cur_timeout  = MEAS_TIMEOUT_RST;
  logic              calm         = 1'b0;
  int                ready_hold   = 0;
  int                idle_cycles  = 0;

  periodic_sensor_acquisition_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  acquisition_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fault_count(fault_count),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure: short stalls mostly, now and then a long one
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (calm) begin
      out_ready = 1'b1;
    end else if (out_ready) begin
      out_ready  = 1'b0;
      ready_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                : $urandom_range(10, 40);
    end else begin
      out_ready  = 1'b1;
      ready_hold = $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] pick_driver_status();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return DRV_OK;
    end else if (r < 85) begin
      return DRV_BUSY;
    end else if (r < 95) begin
      return DRV_ERROR;
    end
    return DRV_UNDEFINED;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_word();
    return SAMPLE_W'({$urandom, $urandom});
  endfunction

  // steps sized against the current intervals so triggers, reads and
  // timeouts all come round; a few jump anywhere in the wrapping range
  function automatic logic [TIME_W-1:0] time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return $urandom_range(0, 2);
    end else if (r < 65) begin
      return TIME_W'($urandom % (64'(cur_timeout) + 1));
    end else if (r < 90) begin
      return cur_interval + $urandom_range(0, 2) - 1;
    end
    return $urandom;
  endfunction

  // entered and left at a falling edge; valid stays up between requests unless a gap is drawn
  task automatic send_request(input logic func, input logic [TIME_W-1:0] now,
                              input logic [1:0] drv,
                              input logic [SAMPLE_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              = 1'b1;
    in_data.func          = func;
    in_data.now_ms        = now;
    in_data.driver_status = drv;
    in_data.sample_word   = word;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_SAMPLE_INTERVAL) begin
      cur_interval = value;
    end else begin
      cur_timeout = value;
    end
  endtask

  task automatic run_phase(input int count, input logic [CFG_W-1:0] interval,
                           input logic [CFG_W-1:0] timeout);
    logic func;
    write_reg(REG_SAMPLE_INTERVAL, interval);
    write_reg(REG_MEAS_TIMEOUT, timeout);
    calm     = ($urandom_range(0, 3) == 0);
    clock_ms = $urandom;
    send_request(FUNC_BEGIN, clock_ms, DRV_OK, random_word());
    for (int i = 0; i < count; i++) begin
      // halfway through, the sender holds off until every result is back
      if (i == count / 2) begin
        drain();
      end
      func     = ($urandom_range(0, 24) == 0) ? FUNC_BEGIN : FUNC_POLL;
      clock_ms = clock_ms + time_step();
      send_request(func, clock_ms, pick_driver_status(), random_word());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed part, reset intervals of 1000 and 100 ms
    send_request(FUNC_POLL,  32'd5,    DRV_OK,        random_word());
    send_request(FUNC_BEGIN, 32'd6,    DRV_BUSY,      random_word());
    send_request(FUNC_BEGIN, 32'd7,    DRV_UNDEFINED, random_word());
    send_request(FUNC_BEGIN, 32'd8,    DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd8,    DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd50,   DRV_BUSY,      random_word());
    send_request(FUNC_POLL,  32'd108,  DRV_BUSY,      random_word());
    send_request(FUNC_POLL,  32'd500,  DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd1008, DRV_ERROR,     random_word());
    send_request(FUNC_POLL,  32'd2007, DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd2008, DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd2010, DRV_OK,        '1);
    send_request(FUNC_POLL,  32'd3008, DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd3009, DRV_ERROR,     random_word());
    send_request(FUNC_POLL,  32'd4008, DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd4009, DRV_UNDEFINED, random_word());
    // across the time wrap
    send_request(FUNC_POLL,  '1,       DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd0,    DRV_OK,        '0);
    send_request(FUNC_POLL,  32'd998,  DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd999,  DRV_UNDEFINED, random_word());
    // zero intervals make begin fail and leave the block disarmed
    write_reg(REG_SAMPLE_INTERVAL, '0);
    send_request(FUNC_BEGIN, 32'd1200, DRV_OK,        random_word());
    send_request(FUNC_POLL,  32'd1300, DRV_OK,        random_word());
    write_reg(REG_SAMPLE_INTERVAL, 32'd1000);
    write_reg(REG_MEAS_TIMEOUT, '0);
    send_request(FUNC_BEGIN, 32'd1400, DRV_OK,        random_word());

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          run_phase(150, 32'd1, 32'd1);
        end
        1: begin
          run_phase(150, '1, '1);
        end
        2: begin
          run_phase(40, '0, $urandom_range(1, 50));
        end
        3: begin
          run_phase(40, $urandom_range(1, 50), '0);
        end
        default: begin
          run_phase(150, $urandom_range(1, 300), $urandom_range(1, 120));
        end
      endcase
    end

    drain();
    if (fault_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
